FILE: rtl/ddd_pkg.sv
// Shared constants, types and helper functions for the dataflow depth tracker.
package ddd_pkg;

    localparam int NUM_REGS_DEF    = 32;
    localparam int MAX_INSTS_DEF   = 4096;
    localparam int NUM_OPCODES_DEF = 16;

    localparam int OP_W      = 4;
    localparam int REG_W     = 5;
    localparam int IDX_OUT_W = 12;
    localparam int DEPTH_W   = 24;
    localparam int LAT_W     = 8;
    localparam int TBL_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LAT_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_HIGH = CFG_IDX_W'(1);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Classified instruction as it waits between front and back.
    typedef struct packed {
        logic             new_program;
        logic [LAT_W-1:0] latency;
        logic             s1_ok;
        logic [REG_W-1:0] s1;
        logic             s2_ok;
        logic [REG_W-1:0] s2;
        logic             dst_ok;
        logic [REG_W-1:0] dst;
    } t_ddd_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic vld;
    } t_ddd_qstat;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] inst_index;
        logic                 dep_one_valid;
        logic [IDX_OUT_W-1:0] dep_one_index;
        logic                 dep_two_valid;
        logic [IDX_OUT_W-1:0] dep_two_index;
        logic [DEPTH_W-1:0]   depth;
    } t_ddd_result;

    // Pick the byte for an opcode out of the two table words.
    function automatic logic [LAT_W-1:0] lat_pick(
        input logic [TBL_W-1:0] lo,
        input logic [TBL_W-1:0] hi,
        input logic [OP_W-1:0]  op
    );
        logic [TBL_W-1:0] word;
        word = op[OP_W-1] ? hi : lo;
        return word[op[OP_W-2:0]*LAT_W +: LAT_W];
    endfunction

endpackage

FILE: rtl/ddd_if.sv
// Channel interfaces: instruction input, result output and configuration writes.
interface ddd_in_if;
    import ddd_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [REG_W-1:0] source_one;
    logic [REG_W-1:0] source_two;
    logic [REG_W-1:0] dest_reg;
    logic             new_program;
    modport source (output valid, opcode, source_one, source_two, dest_reg, new_program,
                    input ready);
    modport sink   (input valid, opcode, source_one, source_two, dest_reg, new_program,
                    output ready);
endinterface

interface ddd_out_if;
    import ddd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] inst_index;
    logic                 dep_one_valid;
    logic [IDX_OUT_W-1:0] dep_one_index;
    logic                 dep_two_valid;
    logic [IDX_OUT_W-1:0] dep_two_index;
    logic [DEPTH_W-1:0]   depth;
    modport source (output valid, inst_index, dep_one_valid, dep_one_index, dep_two_valid,
                    dep_two_index, depth, input ready);
    modport sink   (input valid, inst_index, dep_one_valid, dep_one_index, dep_two_valid,
                    dep_two_index, depth, output ready);
endinterface

interface ddd_cfg_if;
    import ddd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TBL_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dataflow_dependency_depth.sv
// An accepted instruction beat passes the queue, the lookup register and the output register.
// Throughput: one instruction per cycle unless the result sink stalls; the writer memory's two
//   read ports are used once per instruction, its write port at most once, last write forwarded.
// Reset (synchronous, active low): empties the queue and pipeline, clears every writer valid
//   bit, the instruction counter and both latency table words; no clearing pass is needed.
module dataflow_dependency_depth #(
    parameter int NUM_REGS    = ddd_pkg::NUM_REGS_DEF,
    parameter int MAX_INSTS   = ddd_pkg::MAX_INSTS_DEF,
    parameter int NUM_OPCODES = ddd_pkg::NUM_OPCODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ddd_in_if.sink    i_in,
    ddd_out_if.source o_out,
    ddd_cfg_if.sink   i_cfg
);
    import ddd_pkg::*;

    // Latency table words; the user must write them only while the block is idle (not enforced).
    logic [TBL_W-1:0] r_lat_low;
    logic [TBL_W-1:0] r_lat_high;

    t_ddd_qstat q_stat;
    t_ddd_item  push_item;
    t_ddd_item  head_item;
    logic       q_push;
    logic       q_pop;

    // Config channel never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_low  <= '0;
            r_lat_high <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LAT_LOW: begin
                    r_lat_low <= i_cfg.data;
                end
                CFG_LAT_HIGH: begin
                    r_lat_high <= i_cfg.data;
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Front: take the beat, attach latency and register range flags.
    ddd_front #(
        .NUM_REGS    (NUM_REGS),
        .NUM_OPCODES (NUM_OPCODES)
    ) u_front (
        .i_in       (i_in),
        .i_lat_low  (r_lat_low),
        .i_lat_high (r_lat_high),
        .i_qstat    (q_stat),
        .o_push     (q_push),
        .o_item     (push_item)
    );

    // Queue: decouple front stalls from back stalls.
    ddd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_qstat (q_stat),
        .o_head  (head_item)
    );

    // Back: read writers, compute depth, record this instruction as writer, present result.
    ddd_back #(
        .NUM_REGS  (NUM_REGS),
        .MAX_INSTS (MAX_INSTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (q_stat),
        .i_head  (head_item),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    // An accepted beat always lands in the queue.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> q_stat.vld)
        else $error("accepted beat did not reach the queue");

    // The back end never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.vld)
        else $error("pop from empty queue");

    // A missing producer reports index zero.
    a_dep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (!o_out.dep_one_valid || !o_out.dep_two_valid) |->
        ((o_out.dep_one_valid || o_out.dep_one_index == '0) &&
         (o_out.dep_two_valid || o_out.dep_two_index == '0)))
        else $error("producer index nonzero without producer");

endmodule

FILE: rtl/ddd_front.sv
// Front end: accept instruction beats, look up latency and range-check registers.
module ddd_front #(
    parameter int NUM_REGS    = ddd_pkg::NUM_REGS_DEF,
    parameter int NUM_OPCODES = ddd_pkg::NUM_OPCODES_DEF
) (
    ddd_in_if.sink                       i_in,
    input  logic [ddd_pkg::TBL_W-1:0]    i_lat_low,
    input  logic [ddd_pkg::TBL_W-1:0]    i_lat_high,
    input  ddd_pkg::t_ddd_qstat          i_qstat,
    output logic                         o_push,
    output ddd_pkg::t_ddd_item           o_item
);
    import ddd_pkg::*;

    logic op_ok;

    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

    // Opcodes past the table count have zero latency.
    assign op_ok = 32'(i_in.opcode) < NUM_OPCODES;

    always_comb begin
        o_item.new_program = i_in.new_program;
        o_item.latency     = op_ok ? lat_pick(i_lat_low, i_lat_high, i_in.opcode) : '0;
        o_item.s1_ok       = 32'(i_in.source_one) < NUM_REGS;
        o_item.s1          = i_in.source_one;
        o_item.s2_ok       = 32'(i_in.source_two) < NUM_REGS;
        o_item.s2          = i_in.source_two;
        o_item.dst_ok      = 32'(i_in.dest_reg) < NUM_REGS;
        o_item.dst         = i_in.dest_reg;
    end

endmodule

FILE: rtl/ddd_queue.sv
// Small FIFO of classified instructions between the front end and the back end.
module ddd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ddd_pkg::t_ddd_item  i_item,
    input  logic                i_pop,
    output ddd_pkg::t_ddd_qstat o_qstat,
    output ddd_pkg::t_ddd_item  o_head
);
    import ddd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_ddd_item        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_qstat.full = (r_cnt == CNT_FULL);
    assign o_qstat.vld  = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/ddd_back.sv
// Back end: register scoreboard lookup, depth compute, writer update and result register.
module ddd_back #(
    parameter int NUM_REGS  = ddd_pkg::NUM_REGS_DEF,
    parameter int MAX_INSTS = ddd_pkg::MAX_INSTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddd_pkg::t_ddd_qstat i_qstat,
    input  ddd_pkg::t_ddd_item  i_head,
    output logic                o_pop,
    ddd_out_if.source           o_out
);
    import ddd_pkg::*;

    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int IDXW   = $clog2(MAX_INSTS);
    localparam int ENT_W  = IDXW + DEPTH_W;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_INSTS - 1);

    // Writer memory: {writer index, ready time}; valid bits live in flops.
    logic [ENT_W-1:0]    r_mem [NUM_REGS];
    logic [ENT_W-1:0]    r_rd1, r_rd2;
    logic [NUM_REGS-1:0] r_valid, n_valid;

    // Most recent write, to cover the read that raced it.
    logic              r_fw_vld;
    logic [REG_AW-1:0] r_fw_dst;
    logic [ENT_W-1:0]  r_fw_ent;

    logic        r_s2_vld;
    t_ddd_item   r_s2;
    logic [IDXW-1:0] r_next, n_next;

    logic        r_out_vld;
    t_ddd_result r_out, n_out;

    logic              out_free, s2_fire;
    logic [REG_AW-1:0] a1, a2, ad;
    logic              hit1, hit2;
    logic [ENT_W-1:0]  ent1, ent2, n_ent;
    logic [DEPTH_W-1:0] t1, t2, dep, done;
    logic [DEPTH_W:0]   sum;
    logic [IDXW-1:0]    i1, i2, me;

    assign out_free = !r_out_vld || o_out.ready;
    assign s2_fire  = r_s2_vld && out_free;
    assign o_pop    = i_qstat.vld && (!r_s2_vld || out_free);

    always_comb begin
        a1   = REG_AW'(r_s2.s1);
        a2   = REG_AW'(r_s2.s2);
        ad   = REG_AW'(r_s2.dst);
        hit1 = r_s2.s1_ok && !r_s2.new_program && r_valid[a1];
        hit2 = r_s2.s2_ok && !r_s2.new_program && r_valid[a2];
        ent1 = (r_fw_vld && r_fw_dst == a1) ? r_fw_ent : r_rd1;
        ent2 = (r_fw_vld && r_fw_dst == a2) ? r_fw_ent : r_rd2;
        t1   = hit1 ? ent1[DEPTH_W-1:0] : '0;
        t2   = hit2 ? ent2[DEPTH_W-1:0] : '0;
        i1   = hit1 ? ent1[ENT_W-1:DEPTH_W] : '0;
        i2   = hit2 ? ent2[ENT_W-1:DEPTH_W] : '0;
        dep  = (t1 >= t2) ? t1 : t2;
        sum  = {1'b0, dep} + (DEPTH_W + 1)'(r_s2.latency);
        done = sum[DEPTH_W] ? DEPTH_MAX : sum[DEPTH_W-1:0];
        me   = r_s2.new_program ? '0 : r_next;
        n_next = (me == IDX_LAST) ? '0 : me + 1'b1;
        n_ent  = {me, done};

        n_valid = r_valid;
        if (r_s2.new_program) begin
            n_valid = '0;
        end
        if (r_s2.dst_ok) begin
            n_valid[ad] = 1'b1;
        end

        n_out.inst_index    = IDX_OUT_W'(me);
        n_out.dep_one_valid = hit1;
        n_out.dep_one_index = IDX_OUT_W'(i1);
        n_out.dep_two_valid = hit2;
        n_out.dep_two_index = IDX_OUT_W'(i2);
        n_out.depth         = dep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fw_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_next    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s2_vld <= 1'b1;
            end else if (s2_fire) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_fire) begin
                r_valid <= n_valid;
                r_next  <= n_next;
                if (r_s2.dst_ok) begin
                    r_fw_vld <= 1'b1;
                end
            end
            if (s2_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2  <= i_head;
            r_rd1 <= r_mem[REG_AW'(i_head.s1)];
            r_rd2 <= r_mem[REG_AW'(i_head.s2)];
        end
        if (s2_fire && r_s2.dst_ok) begin
            r_mem[ad] <= n_ent;
            r_fw_dst  <= ad;
            r_fw_ent  <= n_ent;
        end
        if (s2_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.inst_index    = r_out.inst_index;
    assign o_out.dep_one_valid = r_out.dep_one_valid;
    assign o_out.dep_one_index = r_out.dep_one_index;
    assign o_out.dep_two_valid = r_out.dep_two_valid;
    assign o_out.dep_two_index = r_out.dep_two_index;
    assign o_out.depth         = r_out.depth;

endmodule

FILE: bench/tb_dataflow_dependency_depth.sv
// Self-checking testbench for the dataflow dependency depth tracker.
module tb_dataflow_dependency_depth;
    import ddd_pkg::*;

    // Run guard, in time units (two per clock cycle).
    localparam int RUN_LIMIT = 1_000_000;
    // Items in each random phase.
    localparam int PHASE_ITEMS = 80;
    // Length of the full-rate dependency chain.
    localparam int CHAIN_ITEMS = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ddd_in_if  in_bus ();
    ddd_out_if out_bus ();
    ddd_cfg_if cfg_bus ();

    dataflow_dependency_depth u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: latency table copy and per-register writer scoreboard.
    logic [TBL_W-1:0]     lat_low = '0;
    logic [TBL_W-1:0]     lat_high = '0;
    bit [NUM_REGS_DEF-1:0] reg_has_writer = '0;
    logic [IDX_OUT_W-1:0] reg_writer_idx [NUM_REGS_DEF];
    logic [DEPTH_W-1:0]   reg_ready_at [NUM_REGS_DEF];
    int unsigned          next_inst = 0;

    // Results still owed by the block, oldest first.
    t_ddd_result pending_results[$];
    int          failures = 0;
    // Random gaps on both sides; cleared for stretches at full rate.
    bit          idle_enable = 1'b1;

    // Track one instruction through the scoreboard and return the result
    // that the block must give for it.
    function automatic t_ddd_result track_instr(
        input logic [OP_W-1:0]  op,
        input logic [REG_W-1:0] s1,
        input logic [REG_W-1:0] s2,
        input logic [REG_W-1:0] dst,
        input logic             np
    );
        t_ddd_result        r;
        logic [DEPTH_W-1:0] t1;
        logic [DEPTH_W-1:0] t2;
        logic [DEPTH_W-1:0] start;
        logic [DEPTH_W:0]   finish;
        logic [LAT_W-1:0]   lat;
        logic [TBL_W-1:0]   word;
        // A new program forgets every writer and restarts numbering first.
        if (np) begin
            reg_has_writer = '0;
            next_inst = 0;
        end
        r = '0;
        r.inst_index = IDX_OUT_W'(next_inst);
        t1 = '0;
        t2 = '0;
        // Look up both producers before the destination is overwritten, so an
        // instruction that reads and writes one register sees the old writer.
        if (s1 < NUM_REGS_DEF && reg_has_writer[s1]) begin
            r.dep_one_valid = 1'b1;
            r.dep_one_index = reg_writer_idx[s1];
            t1 = reg_ready_at[s1];
        end
        if (s2 < NUM_REGS_DEF && reg_has_writer[s2]) begin
            r.dep_two_valid = 1'b1;
            r.dep_two_index = reg_writer_idx[s2];
            t2 = reg_ready_at[s2];
        end
        start = (t1 >= t2) ? t1 : t2;
        // Opcodes outside the table cost nothing.
        lat = '0;
        if (op < NUM_OPCODES_DEF) begin
            word = op[OP_W-1] ? lat_high : lat_low;
            lat = LAT_W'(word >> (op[OP_W-2:0] * LAT_W));
        end
        // Add in one bit more, then clamp the completion time.
        finish = {1'b0, start} + {{(DEPTH_W + 1 - LAT_W){1'b0}}, lat};
        if (finish > {1'b0, DEPTH_MAX})
            finish = {1'b0, DEPTH_MAX};
        if (dst < NUM_REGS_DEF) begin
            reg_has_writer[dst] = 1'b1;
            reg_writer_idx[dst] = r.inst_index;
            reg_ready_at[dst] = finish[DEPTH_W-1:0];
        end
        next_inst = (next_inst + 1) % MAX_INSTS_DEF;
        r.depth = start;
        return r;
    endfunction

    // Favor a few hot registers so that dependencies chain often.
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 3) != 0)
            return REG_W'($urandom_range(0, 3));
        return REG_W'($urandom_range(0, NUM_REGS_DEF - 1));
    endfunction

    // Send one instruction beat; call at a rising edge. Valid stays high on
    // return so that a back-to-back beat needs no second assignment.
    task automatic send_instr(
        input logic [OP_W-1:0]  op,
        input logic [REG_W-1:0] s1,
        input logic [REG_W-1:0] s2,
        input logic [REG_W-1:0] dst,
        input logic             np
    );
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.opcode      <= op;
        in_bus.source_one  <= s1;
        in_bus.source_two  <= s2;
        in_bus.dest_reg    <= dst;
        in_bus.new_program <= np;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_results.push_back(track_instr(op, s1, s2, dst, np));
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Program both latency table words; call only while the block is idle.
    task automatic set_latency_table(input logic [TBL_W-1:0] lo, input logic [TBL_W-1:0] hi);
        for (int k = 0; k < 2; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= (k == 0) ? CFG_LAT_LOW : CFG_LAT_HIGH;
            cfg_bus.data  <= (k == 0) ? lo : hi;
            do @(posedge i_clk); while (!cfg_bus.ready);
            if (k == 0)
                lat_low = lo;
            else
                lat_high = hi;
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [TBL_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic check_field(
        input string              field,
        input logic [IDX_OUT_W-1:0] at,
        input logic [DEPTH_W-1:0] want,
        input logic [DEPTH_W-1:0] got
    );
        if (want !== got) begin
            failures++;
            if (failures <= 10)
                $display("mismatch at instruction %0d: %s expected %0d, got %0d",
                         at, field, want, got);
        end
    endtask

    // Result sink: stall ready at random, then compare each accepted beat
    // with the oldest expectation, field by field.
    initial begin : result_checker
        int unsigned stall;
        t_ddd_result want;
        out_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_enable ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result beat with no instruction outstanding: index %0d",
                             out_bus.inst_index);
            end else begin
                want = pending_results.pop_front();
                check_field("inst_index", want.inst_index, DEPTH_W'(want.inst_index),
                            DEPTH_W'(out_bus.inst_index));
                check_field("dep_one_valid", want.inst_index, DEPTH_W'(want.dep_one_valid),
                            DEPTH_W'(out_bus.dep_one_valid));
                check_field("dep_one_index", want.inst_index, DEPTH_W'(want.dep_one_index),
                            DEPTH_W'(out_bus.dep_one_index));
                check_field("dep_two_valid", want.inst_index, DEPTH_W'(want.dep_two_valid),
                            DEPTH_W'(out_bus.dep_two_valid));
                check_field("dep_two_index", want.inst_index, DEPTH_W'(want.dep_two_index),
                            DEPTH_W'(out_bus.dep_two_index));
                check_field("depth", want.inst_index, want.depth, out_bus.depth);
            end
        end
    end

    // Straight after reset both table words are zero, so every depth is zero
    // even along a chain; no configuration write happens before this.
    task automatic test_reset_tables();
        send_instr(OP_W'(5), REG_W'(0), REG_W'(1), REG_W'(2), 1'b0);
        send_instr(OP_W'(12), REG_W'(2), REG_W'(2), REG_W'(2), 1'b0);
        send_instr(OP_W'(0), REG_W'(2), REG_W'(9), REG_W'(9), 1'b0);
        wait_drained();
    endtask

    // Hand-picked trace: every opcode, registers 0 and 31, a register
    // both read and written, both sources the same, one source without a
    // producer, and a program restart in the middle of the stream.
    task automatic test_directed_cases();
        set_latency_table(64'h80_40_20_10_08_04_02_FF, 64'h00_01_7F_FE_C3_3C_AA_55);
        send_instr(OP_W'(0), REG_W'(0), REG_W'(31), REG_W'(0), 1'b1);
        send_instr(OP_W'(1), REG_W'(0), REG_W'(0), REG_W'(0), 1'b0);
        send_instr(OP_W'(15), REG_W'(0), REG_W'(31), REG_W'(31), 1'b0);
        send_instr(OP_W'(2), REG_W'(31), REG_W'(0), REG_W'(31), 1'b0);
        for (int op = 3; op < 15; op++)
            send_instr(OP_W'(op), REG_W'(31), REG_W'(op - 1), REG_W'(op), 1'b0);
        // Restart: nothing from the old program may be seen as a producer.
        send_instr(OP_W'(7), REG_W'(31), REG_W'(0), REG_W'(1), 1'b1);
        send_instr(OP_W'(15), REG_W'(1), REG_W'(1), REG_W'(1), 1'b0);
        send_instr(OP_W'(0), REG_W'(1), REG_W'(14), REG_W'(30), 1'b0);
        wait_drained();
    endtask

    // Random traces under several table settings, the all-zero and all-ones
    // extremes among them; one phase runs with no idling at either side.
    task automatic test_random_traces();
        logic [TBL_W-1:0] lo;
        logic [TBL_W-1:0] hi;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: begin
                    lo = '1;
                    hi = '1;
                end
                2: begin
                    lo = '0;
                    hi = '0;
                end
                default: begin
                    lo = rand_word();
                    hi = rand_word();
                end
            endcase
            set_latency_table(lo, hi);
            idle_enable = (phase != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_instr(OP_W'($urandom_range(0, 15)), pick_reg(), pick_reg(), pick_reg(),
                           ($urandom_range(0, 31) == 0));
            wait_drained();
        end
        idle_enable = 1'b1;
    endtask

    // One dependency chain at full rate: every step costs 255, so the
    // completion time climbs steadily and each producer is the step before.
    task automatic test_full_rate_chain();
        set_latency_table('1, rand_word());
        idle_enable = 1'b0;
        send_instr(OP_W'(0), REG_W'(5), REG_W'(5), REG_W'(5), 1'b1);
        for (int n = 1; n < CHAIN_ITEMS; n++)
            send_instr(OP_W'($urandom_range(0, 7)), REG_W'(5), pick_reg(), REG_W'(5), 1'b0);
        wait_drained();
        idle_enable = 1'b1;
    endtask

    initial begin
        // Drive every input known from time zero, reset held low.
        i_rst_n            <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.opcode      <= '0;
        in_bus.source_one  <= '0;
        in_bus.source_two  <= '0;
        in_bus.dest_reg    <= '0;
        in_bus.new_program <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_LAT_LOW;
        cfg_bus.data       <= '0;
        for (int r = 0; r < NUM_REGS_DEF; r++) begin
            reg_writer_idx[r] = '0;
            reg_ready_at[r] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tables();
        test_directed_cases();
        test_random_traces();
        test_full_rate_chain();

        // Let any stray beat show up before the verdict.
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("** dataflow_dependency_depth: PASSED **");
        end else begin
            $display("** dataflow_dependency_depth: FAILED **");
        end
        $finish;
    end

    // Guard against a hang: a missing beat never drains the expectations.
    initial begin
        #(RUN_LIMIT);
        $display("** dataflow_dependency_depth: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ddd_pkg.sv
rtl/ddd_if.sv
rtl/ddd_front.sv
rtl/ddd_queue.sv
rtl/ddd_back.sv
rtl/dataflow_dependency_depth.sv
bench/tb_dataflow_dependency_depth.sv
